### hdl/ipe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_pkg
// Shared widths, codes and controller/datapath interface types for the
// infix precedence evaluator.
// ----------------------------------------------------------------------------
package ipe_pkg;

    // arithmetic width of the accumulators and the divider
    localparam int VALUE_BITS = 32;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    // port field widths
    localparam int DATA_BITS    = 32;
    localparam int OP_BITS      = 3;
    localparam int S_TDATA_BITS = ((DATA_BITS + OP_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

    // operator codes carried with each operand
    localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
    localparam logic [OP_BITS-1:0] OP_END = 3'd4;

    // pending operator of the open term
    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_MUL,
        TERM_DIV
    } term_op_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic term_pass;
        logic term_mul;
        logic div_start;
        logic term_div;
        logic apply;
    } ipe_cmd_t;

    // datapath to controller
    typedef struct packed {
        term_op_t term_op;
        logic     op_is_end;
        logic     div_done;
        logic     out_full;
    } ipe_status_t;

endpackage

### hdl/ipe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_div
// Iterative radix-2 signed divider, one quotient bit per cycle, truncating
// toward zero. Result is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module ipe_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ipe_pkg::VALUE_BITS-1:0] dividend,
    input  logic [ipe_pkg::VALUE_BITS-1:0] divisor,
    output logic                           done,
    output logic [ipe_pkg::VALUE_BITS-1:0] quotient
);

    localparam int VB = ipe_pkg::VALUE_BITS;
    localparam int CB = ipe_pkg::CNT_BITS;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [VB-1:0] rem_reg, rem_next;
    logic [VB-1:0] quo_reg, quo_next;
    logic [VB-1:0] dvs_reg, dvs_next;
    logic          neg_reg, neg_next;

    logic [VB:0]   rem_shift;
    logic [VB:0]   diff;
    logic          a_neg;
    logic          b_neg;

    // operand signs and one restoring step
    assign a_neg     = dividend[VB-1];
    assign b_neg     = divisor[VB-1];
    assign rem_shift = {rem_reg, quo_reg[VB-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = a_neg ? (~dividend + 1'b1) : dividend;
            dvs_next  = b_neg ? (~divisor + 1'b1) : divisor;
            neg_next  = a_neg ^ b_neg;
        end
        else if (busy_reg)
        begin
            // keep the difference when it did not borrow
            if (!diff[VB])
            begin
                rem_next = diff[VB-1:0];
            end
            else
            begin
                rem_next = rem_shift[VB-1:0];
            end
            quo_next = {quo_reg[VB-2:0], ~diff[VB]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CB'(VB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // restore the sign of the quotient
    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

### hdl/ipe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_dp
// Evaluator datapath: operand latch, running sum and open term, multiplier,
// divider and the output register of the result channel.
// ----------------------------------------------------------------------------
module ipe_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipe_pkg::ipe_cmd_t             cmd,
    output ipe_pkg::ipe_status_t          status,
    input  logic [ipe_pkg::DATA_BITS-1:0] operand,
    input  logic [ipe_pkg::OP_BITS-1:0]   next_op,
    output logic [ipe_pkg::DATA_BITS-1:0] value,
    output logic                          div_by_zero,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int VB = ipe_pkg::VALUE_BITS;
    localparam int DB = ipe_pkg::DATA_BITS;
    localparam int OB = ipe_pkg::OP_BITS;

    logic [VB-1:0]     sum_acc_reg, sum_acc_next;
    logic              sum_sign_reg, sum_sign_next;
    logic [VB-1:0]     term_acc_reg, term_acc_next;
    ipe_pkg::term_op_t term_op_reg, term_op_next;
    logic              error_seen_reg, error_seen_next;
    logic [VB-1:0]     x_reg, x_next;
    logic [OB-1:0]     op_reg, op_next;
    logic [VB-1:0]     term_reg, term_next;
    logic [DB-1:0]     out_value_reg, out_value_next;
    logic              out_div_reg, out_div_next;
    logic              out_valid_reg, out_valid_next;

    logic [VB-1:0]     product;
    logic [VB-1:0]     sum_new;
    logic              div_done;
    logic [VB-1:0]     div_q;
    logic              op_is_end;

    ipe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (term_acc_reg),
        .divisor  (x_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // low half of the term product and the next running sum
    assign product   = term_acc_reg * x_reg;
    assign sum_new   = sum_sign_reg ? (sum_acc_reg - term_reg) : (sum_acc_reg + term_reg);
    assign op_is_end = (op_reg != ipe_pkg::OP_ADD) && (op_reg != ipe_pkg::OP_SUB) &&
                       (op_reg != ipe_pkg::OP_MUL) && (op_reg != ipe_pkg::OP_DIV);

    always_comb
    begin
        sum_acc_next    = sum_acc_reg;
        sum_sign_next   = sum_sign_reg;
        term_acc_next   = term_acc_reg;
        term_op_next    = term_op_reg;
        error_seen_next = error_seen_reg;
        x_next          = x_reg;
        op_next         = op_reg;
        term_next       = term_reg;
        out_value_next  = out_value_reg;
        out_div_next    = out_div_reg;
        out_valid_next  = out_valid_reg;

        // result beat leaves
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // latch the incoming beat
        if (cmd.load_in)
        begin
            x_next  = VB'($signed(operand));
            op_next = next_op;
        end

        // close the open term
        if (cmd.term_pass)
        begin
            term_next = x_reg;
        end
        if (cmd.term_mul)
        begin
            term_next = product;
        end
        if (cmd.term_div)
        begin
            if (x_reg == '0)
            begin
                term_next       = '0;
                error_seen_next = 1'b1;
            end
            else
            begin
                term_next = div_q;
            end
        end

        // act on the operator that follows the operand
        if (cmd.apply)
        begin
            priority if (op_reg == ipe_pkg::OP_ADD || op_reg == ipe_pkg::OP_SUB)
            begin
                sum_acc_next  = sum_new;
                sum_sign_next = op_reg[0];
                term_acc_next = '0;
                term_op_next  = ipe_pkg::TERM_NONE;
            end
            else if (op_reg == ipe_pkg::OP_MUL)
            begin
                term_acc_next = term_reg;
                term_op_next  = ipe_pkg::TERM_MUL;
            end
            else if (op_reg == ipe_pkg::OP_DIV)
            begin
                term_acc_next = term_reg;
                term_op_next  = ipe_pkg::TERM_DIV;
            end
            else
            begin
                out_value_next  = error_seen_reg ? '0 : DB'($signed(sum_new));
                out_div_next    = error_seen_reg;
                out_valid_next  = 1'b1;
                sum_acc_next    = '0;
                sum_sign_next   = 1'b0;
                term_acc_next   = '0;
                term_op_next    = ipe_pkg::TERM_NONE;
                error_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_acc_reg    <= '0;
            sum_sign_reg   <= 1'b0;
            term_acc_reg   <= '0;
            term_op_reg    <= ipe_pkg::TERM_NONE;
            error_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            sum_acc_reg    <= sum_acc_next;
            sum_sign_reg   <= sum_sign_next;
            term_acc_reg   <= term_acc_next;
            term_op_reg    <= term_op_next;
            error_seen_reg <= error_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        op_reg        <= op_next;
        term_reg      <= term_next;
        out_value_reg <= out_value_next;
        out_div_reg   <= out_div_next;
    end

    // status back to the controller
    assign status.term_op   = term_op_reg;
    assign status.op_is_end = op_is_end;
    assign status.div_done  = div_done;
    assign status.out_full  = out_valid_reg;

    assign value       = out_value_reg;
    assign div_by_zero = out_div_reg;
    assign out_valid   = out_valid_reg;

`ifndef SYNTH
    // an end beat leaves the evaluator cleared
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.apply && op_is_end) |=> (sum_acc_reg == '0 && !error_seen_reg &&
                                      term_op_reg == ipe_pkg::TERM_NONE))
        else $error("state not cleared after end of expression");

    // a division by zero forces the value to zero
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_div_reg) |-> (out_value_reg == '0))
        else $error("nonzero value with division by zero flag");

    // the quotient is taken only when the divider finishes
    a_div_taken_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.term_div |-> div_done)
        else $error("quotient taken before divider done");
`endif

endmodule

### hdl/ipe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipe_ctrl
// Evaluator sequencer: takes one beat, closes the open term through the
// multiplier or the divider or passes the operand when no term is open, then applies the operator.
// ----------------------------------------------------------------------------
module ipe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ipe_pkg::ipe_status_t status,
    output ipe_pkg::ipe_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV_WAIT,
        S_APPLY
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // pick the unit that closes the term
                unique case (status.term_op)
                    ipe_pkg::TERM_MUL:
                    begin
                        cmd.term_mul = 1'b1;
                        state_next   = S_APPLY;
                    end
                    ipe_pkg::TERM_DIV:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_WAIT;
                    end
                    default:
                    begin
                        cmd.term_pass = 1'b1;
                        state_next    = S_APPLY;
                    end
                endcase
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.term_div = 1'b1;
                    state_next   = S_APPLY;
                end
            end
            S_APPLY:
            begin
                // an end beat waits for a free output register
                if (!(status.op_is_end && status.out_full))
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/infix_precedence_evaluator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_precedence_evaluator_unit
// Evaluates a flat integer expression of + - * / with the usual precedence.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per operand, carrying the operand and the operator
//   that follows it (add, subtract, multiply, divide, end; codes above end
//   act as end). m_* channel: one beat per end code with the 32-bit value
//   and a division-by-zero flag (value is then 0).
//   An input beat passes S_IDLE, S_EVAL and S_APPLY; when the open term
//   divides, it also waits in S_DIV_WAIT on the radix-2 divider, which
//   produces one quotient bit per cycle over 32 bits.
//   The end beat's term is closed into the term register, then S_APPLY
//   loads the result register that drives m_tvalid, holding while an
//   earlier result still waits.
//   A new expression may start while the previous result waits; only a
//   second end beat stalls until the waiting result is taken.
//   Reset (rst_n low) clears the sum, the open term, the error flag and any
//   waiting result; s_tready is high from the first cycle after reset.
//   A stall on m_tready holds the result and, at a second end beat, the input; no beat is lost.
// ----------------------------------------------------------------------------
module infix_precedence_evaluator_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] operand, [34:32] next_op, [39:35] zero
    input  logic [ipe_pkg::S_TDATA_BITS-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] value
    output logic [ipe_pkg::M_TDATA_BITS-1:0] m_tdata,
    // [0] div_by_zero
    output logic                             m_tuser
);

    localparam int DB = ipe_pkg::DATA_BITS;
    localparam int OB = ipe_pkg::OP_BITS;

    ipe_pkg::ipe_cmd_t    cmd;
    ipe_pkg::ipe_status_t status;
    logic [DB-1:0]        value;

    ipe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ipe_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operand     (s_tdata[DB-1:0]),
        .next_op     (s_tdata[DB+OB-1:DB]),
        .value       (value),
        .div_by_zero (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    // value padded to whole bytes
    assign m_tdata = ipe_pkg::M_TDATA_BITS'(value);

endmodule
